// ----- rtl/dtip_pkg.sv -----
// dtip_pkg: beat types, type codes, character codes and range limits
// for the decimal text integer parser. No dependencies.
`default_nettype none

package dtip_pkg;

  // target type codes of the value_type register
  localparam logic [2:0] TYPE_I8  = 3'd0;
  localparam logic [2:0] TYPE_U8  = 3'd1;
  localparam logic [2:0] TYPE_I16 = 3'd2;
  localparam logic [2:0] TYPE_U16 = 3'd3;
  localparam logic [2:0] TYPE_I32 = 3'd4;
  localparam logic [2:0] TYPE_U32 = 3'd5;
  localparam logic [2:0] TYPE_I64 = 3'd6;
  localparam logic [2:0] TYPE_U64 = 3'd7;

  localparam logic [2:0] TYPE_RESET = TYPE_I64;

  // character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] value;
    logic        ok;
  } out_beat_t;

  // largest magnitude allowed for a positive number of each type
  function automatic logic [63:0] pos_limit(input logic [2:0] t);
    logic [63:0] lim;
    case (t)
      TYPE_I8:  lim = 64'd127;
      TYPE_U8:  lim = 64'd255;
      TYPE_I16: lim = 64'd32767;
      TYPE_U16: lim = 64'd65535;
      TYPE_I32: lim = 64'd2147483647;
      TYPE_U32: lim = 64'd4294967295;
      TYPE_I64: lim = 64'h7FFF_FFFF_FFFF_FFFF;
      default:  lim = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return lim;
  endfunction

  // largest magnitude allowed for a negative number (i64 keeps 2^63-1)
  function automatic logic [63:0] neg_limit(input logic [2:0] t);
    logic [63:0] lim;
    case (t)
      TYPE_I8:  lim = 64'd128;
      TYPE_I16: lim = 64'd32768;
      TYPE_I32: lim = 64'd2147483648;
      TYPE_I64: lim = 64'h7FFF_FFFF_FFFF_FFFF;
      default:  lim = 64'd0;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/decimal_text_integer_parser.sv -----
// decimal_text_integer_parser: parses one line of ASCII text, one character
// per beat, into a 64-bit integer with a range check. Depends on dtip_pkg.
//
//   channel      signals                               direction
//   char         char_valid, char_ready, char_beat     in, one character or line end
//   result       result_valid, result_ready, result    out, value and ok per line
//   value_type   value_type_we, value_type_data        in, target type register
//
// One character beat is taken every cycle unless a line end stalls. A beat lands in an input register
// and the parse state (multiply by ten as two shifts and two 68-bit adds) is
// updated from it in the next cycle; a line end loads the result register as it
// leaves the input register. Only a line-end beat can stall, when the result
// register is still full; plain characters always drain. rst clears the parse
// state, the valid flags and sets value_type to i64.
`default_nettype none

module decimal_text_integer_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  char_valid,
  output logic                       char_ready,
  input  wire dtip_pkg::in_beat_t    char_beat,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output dtip_pkg::out_beat_t        result,
  input  wire logic                  value_type_we,
  input  wire logic [2:0]            value_type_data
);
  import dtip_pkg::*;

  typedef enum logic [2:0] {
    PH_SKIP, PH_SIGNED, PH_DIGITS, PH_DONE, PH_ERROR
  } phase_t;

  logic [2:0]  value_type;
  logic        s1_valid;
  in_beat_t    s1_beat;
  logic        advance;
  logic        line_done;

  phase_t      phase, phase_next;
  logic        negative, negative_next;
  logic [63:0] magnitude, magnitude_next;
  logic        overflowed, overflowed_next;

  logic        is_digit;
  logic        take_digit;
  logic [67:0] scaled;
  out_beat_t   result_next;

  // input stage moves unless a line end meets a full result register
  assign advance    = s1_valid && (!s1_beat.line_end || !result_valid || result_ready);
  assign line_done  = advance && s1_beat.line_end;
  assign char_ready = !s1_valid || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      value_type <= TYPE_RESET;
    end else if (value_type_we) begin
      value_type <= value_type_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ready) begin
      s1_valid <= char_valid;
    end
    if (char_ready && char_valid) begin
      s1_beat <= char_beat;
    end
  end

  // next parse state from the registered character
  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    magnitude_next  = magnitude;
    overflowed_next = overflowed;
    take_digit      = 1'b0;
    is_digit        = (s1_beat.char_code >= CHAR_ZERO) && (s1_beat.char_code <= CHAR_NINE);
    scaled          = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1)
                      + {64'b0, s1_beat.char_code[3:0]};

    unique case (phase)
      PH_SKIP: begin
        if (s1_beat.char_code == CHAR_SPACE || s1_beat.char_code == CHAR_TAB) begin
          phase_next = PH_SKIP;
        end else if (s1_beat.char_code == CHAR_MINUS) begin
          negative_next = 1'b1;
          phase_next    = PH_SIGNED;
        end else if (s1_beat.char_code == CHAR_PLUS) begin
          phase_next = PH_SIGNED;
        end else if (is_digit) begin
          take_digit = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_SIGNED: begin
        if (is_digit) begin
          take_digit = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          take_digit = 1'b1;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase

    // accumulate; anything above 64 bits sets the sticky overflow
    if (take_digit && !overflowed) begin
      if (scaled[67:64] != 4'd0) begin
        overflowed_next = 1'b1;
      end else begin
        magnitude_next = scaled[63:0];
      end
    end
  end

  // range check at line end
  always_comb begin
    result_next.value = 64'd0;
    result_next.ok    = 1'b0;
    if ((phase == PH_DIGITS || phase == PH_DONE) && !overflowed) begin
      if (negative) begin
        if (!value_type[0] && magnitude <= neg_limit(value_type)) begin
          result_next.ok    = 1'b1;
          result_next.value = 64'd0 - magnitude;
        end
      end else if (magnitude <= pos_limit(value_type)) begin
        result_next.ok    = 1'b1;
        result_next.value = magnitude;
      end
    end
  end

  // parse state, cleared after each line
  always_ff @(posedge clk) begin
    if (rst || line_done) begin
      phase      <= PH_SKIP;
      negative   <= 1'b0;
      magnitude  <= 64'd0;
      overflowed <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      negative   <= negative_next;
      magnitude  <= magnitude_next;
      overflowed <= overflowed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (line_done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (line_done) begin
      result <= result_next;
    end
  end

  // a rejected line always reports zero
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.ok |-> result.value == 64'd0)
    else $error("rejected line with nonzero value");

  // a plain character never holds up the input
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_beat.line_end |-> char_ready)
    else $error("character beat stalled");

  // the parse state restarts after every line
  assert property (@(posedge clk) disable iff (rst)
    line_done |=> phase == PH_SKIP && !negative && !overflowed && magnitude == 64'd0)
    else $error("parse state not cleared after line end");

  // overflow stays set within a line
  assert property (@(posedge clk) disable iff (rst)
    overflowed && !line_done |=> overflowed)
    else $error("overflow flag dropped inside a line");

endmodule

`default_nettype wire

// ----- tb/decimal_text_integer_parser_tb.sv -----
`timescale 1ns / 1ps
// decimal_text_integer_parser_tb: self-checking bench for the decimal text parser.
// A table of lines and then random lines are sent against a line-level model.
// Depends on dtip_pkg and decimal_text_integer_parser.

module decimal_text_integer_parser_tb;
  import dtip_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int GROUP_BEATS     = 45;
  localparam int NO_LEAD         = -1;

  typedef enum logic [2:0] {
    SCAN_BLANK, SCAN_SIGN, SCAN_DIGITS, SCAN_TAIL, SCAN_BAD
  } scan_phase_t;

  typedef struct {
    logic [2:0]  vtype;
    int          lead;
    string       text;
    bit          known;
    logic [63:0] value;
    logic        ok;
  } table_row_t;

  typedef struct packed {
    logic      known;
    out_beat_t beat;
  } table_answer_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  in_beat_t   char_beat = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  out_beat_t  result;
  logic       value_type_we = 1'b0;
  logic [2:0] value_type_data = '0;

  // line model state
  scan_phase_t scan_phase = SCAN_BLANK;
  bit          scan_neg = 1'b0;
  logic [63:0] scan_mag = '0;
  bit          scan_ovf = 1'b0;
  logic [2:0]  model_type = TYPE_RESET;

  out_beat_t     pending_results[$];
  table_answer_t table_answers[$];
  table_row_t    stim_table[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int beats_sent = 0;
  int errors = 0;
  bit hold_off_req = 1'b0;

  decimal_text_integer_parser u_dut (
    .clk             (clk),
    .rst             (rst),
    .char_valid      (char_valid),
    .char_ready      (char_ready),
    .char_beat       (char_beat),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result),
    .value_type_we   (value_type_we),
    .value_type_data (value_type_data)
  );

  always #10 clk = ~clk;

  // largest magnitude a type accepts for each sign
  function automatic logic [63:0] max_magnitude(input logic [2:0] t, input bit neg);
    case (t)
      TYPE_I8:  return neg ? 64'd128 : 64'd127;
      TYPE_U8:  return neg ? 64'd0 : 64'd255;
      TYPE_I16: return neg ? 64'd32768 : 64'd32767;
      TYPE_U16: return neg ? 64'd0 : 64'd65535;
      TYPE_I32: return neg ? 64'd2147483648 : 64'd2147483647;
      TYPE_U32: return neg ? 64'd0 : 64'd4294967295;
      TYPE_I64: return 64'h7FFF_FFFF_FFFF_FFFF;
      default:  return neg ? 64'd0 : 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  task automatic clear_scan();
    scan_phase = SCAN_BLANK;
    scan_neg   = 1'b0;
    scan_mag   = '0;
    scan_ovf   = 1'b0;
  endtask

  // accumulate one digit, sticky overflow past 2^64-1
  task automatic add_digit(input logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c - CHAR_ZERO};
    if (!scan_ovf) begin
      if (scan_mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) scan_ovf = 1'b1;
      else scan_mag = scan_mag * 64'd10 + d;
    end
  endtask

  task automatic scan_char(input logic [7:0] c);
    bit digit;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    case (scan_phase)
      SCAN_BLANK: begin
        if (c == CHAR_MINUS) begin
          scan_neg   = 1'b1;
          scan_phase = SCAN_SIGN;
        end else if (c == CHAR_PLUS) begin
          scan_phase = SCAN_SIGN;
        end else if (digit) begin
          add_digit(c);
          scan_phase = SCAN_DIGITS;
        end else if (c != CHAR_SPACE && c != CHAR_TAB) begin
          scan_phase = SCAN_BAD;
        end
      end
      SCAN_SIGN: begin
        if (digit) begin
          add_digit(c);
          scan_phase = SCAN_DIGITS;
        end else begin
          scan_phase = SCAN_BAD;
        end
      end
      SCAN_DIGITS: begin
        if (digit) add_digit(c);
        else scan_phase = SCAN_TAIL;
      end
      SCAN_TAIL: ;
      default: scan_phase = SCAN_BAD;
    endcase
  endtask

  // line end: syntax and range check against the current type
  task automatic close_line(output out_beat_t r);
    logic [63:0] bound;
    bound   = max_magnitude(model_type, scan_neg);
    r.value = '0;
    r.ok    = 1'b0;
    if ((scan_phase == SCAN_DIGITS || scan_phase == SCAN_TAIL) && !scan_ovf &&
        !(scan_neg && model_type[0]) && scan_mag <= bound) begin
      r.ok    = 1'b1;
      r.value = scan_neg ? (64'd0 - scan_mag) : scan_mag;
    end
    clear_scan();
  endtask

  // watch both channels and the register port at each rising edge
  always @(posedge clk) begin : result_watch
    out_beat_t     predicted;
    out_beat_t     want;
    table_answer_t answer;
    if (rst) begin
      clear_scan();
      model_type = TYPE_RESET;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $display("[%0t] unexpected result: expected none, got value %h ok %b",
                   $time, result.value, result.ok);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (result.value !== want.value) begin
            $display("[%0t] mismatch value: expected %h, got %h",
                     $time, want.value, result.value);
            errors++;
          end
          if (result.ok !== want.ok) begin
            $display("[%0t] mismatch ok: expected %b, got %b", $time, want.ok, result.ok);
            errors++;
          end
        end
      end
      if (value_type_we) model_type = value_type_data;
      if (char_valid && char_ready) begin
        if (char_beat.line_end) begin
          close_line(predicted);
          if (table_answers.size() != 0) begin
            answer = table_answers.pop_front();
            if (answer.known) predicted = answer.beat;
          end
          pending_results.push_back(predicted);
        end else begin
          scan_char(char_beat.char_code);
        end
      end
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // offer one beat, entered and left at a falling edge
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_beat  <= b;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    in_beat_t b;
    b.char_code = c;
    b.line_end  = 1'b0;
    send_beat(b);
  endtask

  task automatic send_end();
    in_beat_t b;
    b.char_code = 8'($urandom_range(255));
    b.line_end  = 1'b1;
    send_beat(b);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] non_digit();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c >= CHAR_ZERO && c <= CHAR_NINE) c = c ^ 8'h40;
    return c;
  endfunction

  // stop offering and wait until the block has nothing left in flight
  task automatic settle();
    char_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_type(input logic [2:0] t);
    value_type_we   <= 1'b1;
    value_type_data <= t;
    @(negedge clk);
    value_type_we   <= 1'b0;
  endtask

  task automatic add_row(input logic [2:0] t, input int lead, input string text,
                         input bit known, input logic [63:0] v, input logic ok);
    table_row_t row;
    row.vtype = t;
    row.lead  = lead;
    row.text  = text;
    row.known = known;
    row.value = v;
    row.ok    = ok;
    stim_table.push_back(row);
  endtask

  // one random line: mostly well-formed numbers, some near the type bounds
  task automatic send_random_line();
    int          pick;
    int          shape;
    bit          neg;
    logic [2:0]  bt;
    logic [63:0] mag;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // raw noise, any byte
      repeat ($urandom_range(6)) send_char(8'($urandom_range(255)));
    end else if (pick < 22) begin
      // sign followed by something other than a digit
      repeat ($urandom_range(1)) send_char($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      send_char($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
      case ($urandom_range(3))
        0: send_char(CHAR_SPACE);
        1: send_char(CHAR_MINUS);
        2: send_char(CHAR_PLUS);
        default: send_char(non_digit());
      endcase
      send_text($sformatf("%0d", $urandom_range(999)));
    end else begin
      shape = $urandom_range(5);
      neg   = ($urandom_range(99) < 35);
      mag   = '0;
      case (shape)
        0: mag = 64'($urandom_range(999));
        1: begin
          bt  = 3'($urandom_range(7));
          mag = max_magnitude(bt, neg) + 64'($urandom_range(4)) - 64'd2;
        end
        2: mag = {$urandom, $urandom} >> $urandom_range(63);
        3: ;
        4: mag = '0;
        default: mag = {$urandom, $urandom};
      endcase
      repeat ($urandom_range(2)) send_char($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      if (neg) send_char(CHAR_MINUS);
      else if ($urandom_range(2) == 0) send_char(CHAR_PLUS);
      if ($urandom_range(9) == 0) send_text("00");
      if (shape == 3) begin
        // straddle the 2^64 boundary on the last digit
        send_text($sformatf("%0d", 64'hFFFF_FFFF_FFFF_FFFF / 64'd10));
        send_char(CHAR_ZERO + 8'($urandom_range(9, 5)));
        repeat ($urandom_range(2)) send_char(CHAR_ZERO + 8'($urandom_range(9)));
      end else begin
        send_text($sformatf("%0d", mag));
      end
      if ($urandom_range(3) == 0) begin
        send_char(non_digit());
        repeat ($urandom_range(3)) send_char(8'($urandom_range(255)));
      end
    end
    send_end();
  endtask

  initial begin : stimulus
    logic [2:0] cur_type;
    logic [2:0] group_type;
    int         i;
    int         ph;
    int         g;
    int         group_start;

    // directed lines, typed answers where obvious
    add_row(TYPE_I64, NO_LEAD, "", 1, 64'd0, 1'b0);
    add_row(TYPE_I64, NO_LEAD, " \t \t", 1, 64'd0, 1'b0);
    add_row(TYPE_I64, NO_LEAD, "+", 1, 64'd0, 1'b0);
    add_row(TYPE_I64, NO_LEAD, "-", 1, 64'd0, 1'b0);
    add_row(TYPE_I64, NO_LEAD, "9223372036854775807", 1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    add_row(TYPE_I64, NO_LEAD, "-9223372036854775807", 1, 64'h8000_0000_0000_0001, 1'b1);
    add_row(TYPE_I64, NO_LEAD, "-9223372036854775808", 1, 64'd0, 1'b0);
    add_row(TYPE_I64, NO_LEAD, "18446744073709551616", 1, 64'd0, 1'b0);
    add_row(TYPE_I64, NO_LEAD, "  -0", 1, 64'd0, 1'b1);
    add_row(TYPE_I64, NO_LEAD, "\t+42abc 7", 0, 64'd0, 1'b0);
    add_row(TYPE_I64, 0, "5", 1, 64'd0, 1'b0);
    add_row(TYPE_I64, NO_LEAD, "12 34", 0, 64'd0, 1'b0);
    add_row(TYPE_I64, NO_LEAD, "x12", 1, 64'd0, 1'b0);
    add_row(TYPE_I64, NO_LEAD, "- 5", 1, 64'd0, 1'b0);
    add_row(TYPE_U64, NO_LEAD, "18446744073709551615", 1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    add_row(TYPE_U64, NO_LEAD, "-0", 1, 64'd0, 1'b0);
    add_row(TYPE_U64, NO_LEAD, "000000000000000000000000000099", 0, 64'd0, 1'b0);
    add_row(TYPE_U64, NO_LEAD, "99999999999999999999999", 1, 64'd0, 1'b0);
    add_row(TYPE_I8, NO_LEAD, "-128", 1, 64'hFFFF_FFFF_FFFF_FF80, 1'b1);
    add_row(TYPE_I8, NO_LEAD, "128", 1, 64'd0, 1'b0);
    add_row(TYPE_I8, NO_LEAD, "+127", 1, 64'd127, 1'b1);
    add_row(TYPE_I8, NO_LEAD, "-129", 1, 64'd0, 1'b0);
    add_row(TYPE_U8, NO_LEAD, "255", 1, 64'd255, 1'b1);
    add_row(TYPE_U8, NO_LEAD, "256", 1, 64'd0, 1'b0);
    add_row(TYPE_U8, 255, "1", 1, 64'd0, 1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 30;
    rx_idle_pct = 49;
    cur_type    = TYPE_RESET;
    for (i = 0; i < stim_table.size(); i++) begin
      if (stim_table[i].vtype !== cur_type) begin
        settle();
        cur_type = stim_table[i].vtype;
        write_type(cur_type);
      end
      table_answers.push_back('{known: stim_table[i].known,
                                beat: '{value: stim_table[i].value, ok: stim_table[i].ok}});
      if (stim_table[i].lead != NO_LEAD) send_char(8'(stim_table[i].lead));
      send_text(stim_table[i].text);
      send_end();
    end

    // random lines in three idling regimes, stepping through every type code
    group_type = TYPE_I8;
    for (ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 49 : 0;
      rx_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 30 : 0;
      for (g = 0; g < 4; g++) begin
        settle();
        write_type(group_type);
        group_type = group_type + 3'd1;
        if (ph == 2 && g == 0) hold_off_req = 1'b1;
        group_start = beats_sent;
        while (beats_sent - group_start < GROUP_BEATS) send_random_line();
      end
    end
    settle();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
